FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_HOLDS(lbl, prop, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/nttc_pkg.sv
// shared constants, types and modular helpers of the ntt convolution
package nttc_pkg;
	localparam int CW = 62;
	localparam int PTS = 64;
	localparam int PTS_W = 6;
	localparam int LOGN_W = 3;
	localparam int MAX_LEN = 32;
	localparam int LEN_W = 6;
	localparam int IDX_W = 5;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PRIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEN1 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN2 = 2'd3;

	localparam logic [CW-1:0] PRIME_RST = 62'd998244353;
	localparam logic [CW-1:0] ROOT_RST = 62'd3;
	localparam logic [LEN_W-1:0] LEN_RST = 6'd1;

	typedef struct packed {
		logic [CW-1:0] prime;
		logic [CW-1:0] root;
		logic [LEN_W-1:0] len1;
		logic [LEN_W-1:0] len2;
	} cfg_t;

	typedef struct packed {
		logic wr;
		logic trig;
		logic kind;
		logic [IDX_W-1:0] idx;
		logic [CW-1:0] coeff;
	} qent_t;

	typedef struct packed {
		logic start;
		logic [CW-1:0] a;
		logic [CW-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [CW-1:0] res;
	} mm_rsp_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v == '0)
			r = LEN_W'(1);
		else if (v > LEN_W'(MAX_LEN))
			r = LEN_W'(MAX_LEN);
		return r;
	endfunction

	function automatic logic [LOGN_W-1:0] ceil_log2(input logic [LEN_W:0] total);
		logic [LOGN_W-1:0] r;
		r = '0;
		for (int k = 0; k < PTS_W; k++) begin
			if (((LEN_W+1)'(1) << k) < total)
				r = LOGN_W'(k + 1);
		end
		return r;
	endfunction

	function automatic logic [PTS_W-1:0] bitrev(input logic [PTS_W-1:0] i,
		input logic [LOGN_W-1:0] logn);
		logic [PTS_W-1:0] r;
		for (int k = 0; k < PTS_W; k++)
			r[k] = i[PTS_W-1-k];
		return r >> (LOGN_W'(PTS_W) - logn);
	endfunction

	function automatic logic [CW-1:0] add_mod(input logic [CW-1:0] x,
		input logic [CW-1:0] y, input logic [CW-1:0] p);
		logic [CW:0] s;
		logic [CW:0] d;
		s = {1'b0, x} + {1'b0, y};
		d = s - {1'b0, p};
		return (s >= {1'b0, p}) ? d[CW-1:0] : s[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] sub_mod(input logic [CW-1:0] x,
		input logic [CW-1:0] y, input logic [CW-1:0] p);
		return (x >= y) ? (x - y) : (x + p - y);
	endfunction
endpackage

FILE: rtl/nttc_if.sv
// item channels of the ntt convolution
interface nttc_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [nttc_pkg::CW-1:0] coeff_value;
	modport source(output valid, kind, coeff_value, input ready);
	modport sink(input valid, kind, coeff_value, output ready);
endinterface

interface nttc_out_if;
	logic valid;
	logic ready;
	logic [nttc_pkg::CW-1:0] product_coeff;
	logic last_coeff;
	modport source(output valid, product_coeff, last_coeff, input ready);
	modport sink(input valid, product_coeff, last_coeff, output ready);
endinterface

FILE: rtl/nttc_queue.sv
// short fifo between the front and the back
module nttc_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input nttc_pkg::qent_t push_ent,
	output logic full,
	input logic pop,
	output nttc_pkg::qent_t head,
	output logic empty
);
	nttc_pkg::qent_t ent_q [nttc_pkg::QDEPTH];
	logic [nttc_pkg::QPTR_W-1:0] wptr_q;
	logic [nttc_pkg::QPTR_W-1:0] rptr_q;
	logic [nttc_pkg::QPTR_W:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == (nttc_pkg::QPTR_W+1)'(nttc_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head = ent_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wptr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

FILE: rtl/nttc_front.sv
// takes coefficient items, tracks fill counts and marks the completing item
module nttc_front (
	input logic clk,
	input logic arst_n,
	input nttc_pkg::cfg_t cfg,
	nttc_in_if.sink coeff_chan,
	input logic q_full,
	output logic q_push,
	output nttc_pkg::qent_t q_ent
);
	logic [nttc_pkg::LEN_W-1:0] c1_q;
	logic [nttc_pkg::LEN_W-1:0] c2_q;
	logic [nttc_pkg::LEN_W-1:0] l1;
	logic [nttc_pkg::LEN_W-1:0] l2;
	logic [nttc_pkg::LEN_W-1:0] c1n;
	logic [nttc_pkg::LEN_W-1:0] c2n;
	logic is_first;
	logic wr;
	logic trig;
	logic acc;

	assign coeff_chan.ready = !q_full;
	assign acc = coeff_chan.valid && !q_full;
	assign l1 = nttc_pkg::eff_len(cfg.len1);
	assign l2 = nttc_pkg::eff_len(cfg.len2);
	assign is_first = !coeff_chan.kind;
	assign wr = is_first ? (c1_q < l1) : (c2_q < l2);
	assign c1n = c1_q + nttc_pkg::LEN_W'(is_first && wr);
	assign c2n = c2_q + nttc_pkg::LEN_W'(!is_first && wr);
	assign trig = (c1n >= l1) && (c2n >= l2);

	assign q_push = acc && (wr || trig);
	always_comb begin
		q_ent.wr = wr;
		q_ent.trig = trig;
		q_ent.kind = coeff_chan.kind;
		q_ent.idx = is_first ? c1_q[nttc_pkg::IDX_W-1:0] : c2_q[nttc_pkg::IDX_W-1:0];
		q_ent.coeff = coeff_chan.coeff_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
		end else if (acc) begin
			c1_q <= trig ? '0 : c1n;
			c2_q <= trig ? '0 : c2n;
		end
	end
endmodule

FILE: rtl/nttc_modmul.sv
// bit-serial modular multiplier, one doubling or one addition per cycle
module nttc_modmul (
	input logic clk,
	input logic arst_n,
	input logic [nttc_pkg::CW-1:0] prime,
	input nttc_pkg::mm_req_t req,
	output nttc_pkg::mm_rsp_t rsp
);
	logic busy_q;
	logic done_q;
	logic ph_q;
	logic [nttc_pkg::PTS_W-1:0] cnt_q;
	logic [nttc_pkg::CW-1:0] r_q;
	logic [nttc_pkg::CW-1:0] a_q;
	logic [nttc_pkg::CW-1:0] b_q;

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q <= 1'b0;
			cnt_q <= '0;
			r_q <= '0;
			a_q <= '0;
			b_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				ph_q <= 1'b0;
				cnt_q <= '0;
				r_q <= '0;
				a_q <= req.a;
				b_q <= req.b;
			end else if (busy_q) begin
				if (!ph_q) begin
					r_q <= nttc_pkg::add_mod(r_q, r_q, prime);
					ph_q <= 1'b1;
				end else begin
					if (b_q[nttc_pkg::CW-1])
						r_q <= nttc_pkg::add_mod(r_q, a_q, prime);
					b_q <= b_q << 1;
					ph_q <= 1'b0;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == nttc_pkg::PTS_W'(nttc_pkg::CW - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end
endmodule

FILE: rtl/nttc_back.sv
// sequencer: stores coefficients, runs the transforms and emits the product
module nttc_back (
	input logic clk,
	input logic arst_n,
	input nttc_pkg::cfg_t cfg,
	input logic q_empty,
	input nttc_pkg::qent_t q_head,
	output logic q_pop,
	output nttc_pkg::mm_req_t mm_req,
	input nttc_pkg::mm_rsp_t mm_rsp,
	nttc_out_if.source result_chan
);
	localparam int CW = nttc_pkg::CW;
	localparam int PW = nttc_pkg::PTS_W;
	localparam int IW = nttc_pkg::IDX_W;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_PREP = 5'd1;
	localparam logic [4:0] S_GSET = 5'd2;
	localparam logic [4:0] S_GINVSET = 5'd3;
	localparam logic [4:0] S_NSET = 5'd4;
	localparam logic [4:0] S_NINVSET = 5'd5;
	localparam logic [4:0] S_LRD = 5'd6;
	localparam logic [4:0] S_LMOD = 5'd7;
	localparam logic [4:0] S_LWR = 5'd8;
	localparam logic [4:0] S_TSTG = 5'd9;
	localparam logic [4:0] S_TWL = 5'd10;
	localparam logic [4:0] S_TBF = 5'd11;
	localparam logic [4:0] S_TMV = 5'd12;
	localparam logic [4:0] S_TRU = 5'd13;
	localparam logic [4:0] S_TU = 5'd14;
	localparam logic [4:0] S_TWB = 5'd15;
	localparam logic [4:0] S_TW = 5'd16;
	localparam logic [4:0] S_PRA = 5'd17;
	localparam logic [4:0] S_PRB = 5'd18;
	localparam logic [4:0] S_PMUL = 5'd19;
	localparam logic [4:0] S_PWR = 5'd20;
	localparam logic [4:0] S_CRD = 5'd21;
	localparam logic [4:0] S_CWR = 5'd22;
	localparam logic [4:0] S_ERD = 5'd23;
	localparam logic [4:0] S_EMUL = 5'd24;
	localparam logic [4:0] S_EOUT = 5'd25;
	localparam logic [4:0] S_ZEMIT = 5'd26;
	localparam logic [4:0] S_PLOOP = 5'd27;
	localparam logic [4:0] S_PR = 5'd28;
	localparam logic [4:0] S_PB = 5'd29;
	localparam logic [4:0] S_MWAIT = 5'd30;

	localparam logic [1:0] TP_FA = 2'd0;
	localparam logic [1:0] TP_FB = 2'd1;
	localparam logic [1:0] TP_INV = 2'd2;

	logic [CW-1:0] work_mem [2*nttc_pkg::PTS];
	logic [CW-1:0] store_mem [2*nttc_pkg::MAX_LEN];
	logic [CW-1:0] work_rd_q;
	logic [CW-1:0] store_rd_q;
	logic work_we;
	logic [PW:0] work_wa;
	logic [CW-1:0] work_wd;
	logic [PW:0] work_ra;
	logic store_we;

	logic [4:0] st_q;
	logic [4:0] mret_q;
	logic [4:0] pret_q;
	logic [1:0] tphase_q;
	logic bank_q;
	logic [nttc_pkg::LEN_W-1:0] l1_q;
	logic [nttc_pkg::LEN_W-1:0] l2_q;
	logic [nttc_pkg::LEN_W:0] total_q;
	logic [nttc_pkg::LOGN_W-1:0] logn_q;
	logic [nttc_pkg::LOGN_W-1:0] stage_q;
	logic [PW:0] idx_q;
	logic [PW-1:0] k_q;
	logic [CW-1:0] g_q;
	logic [CW-1:0] ginv_q;
	logic [CW-1:0] ninv_q;
	logic [CW-1:0] troot_q;
	logic [CW-1:0] wl_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] u_q;
	logic [CW-1:0] v_q;
	logic [CW-1:0] mres_q;
	logic [CW-1:0] pw_r_q;
	logic [CW-1:0] pw_b_q;
	logic [CW-1:0] pw_e_q;
	nttc_pkg::mm_req_t mm_req_q;
	logic out_valid_q;
	logic out_last_q;
	logic [CW-1:0] out_data_q;

	logic [PW:0] n7;
	logic [PW-1:0] hm;
	logic [PW-1:0] half;
	logic [PW-1:0] top;
	logic [PW-1:0] bot;
	logic [PW-1:0] rev_idx;
	logic [PW-1:0] idx6;
	logic [nttc_pkg::LEN_W:0] cur_len;
	logic [CW-1:0] p;
	logic out_free;
	logic out_load;
	logic [nttc_pkg::LEN_W-1:0] pl1;
	logic [nttc_pkg::LEN_W-1:0] pl2;
	logic [nttc_pkg::LEN_W:0] ptotal;

	assign p = cfg.prime;
	assign n7 = (PW+1)'(1) << logn_q;
	assign half = PW'(1) << (stage_q - 1'b1);
	assign hm = half - 1'b1;
	assign top = ((k_q & ~hm) << 1) | (k_q & hm);
	assign bot = top | half;
	assign idx6 = idx_q[PW-1:0];
	assign rev_idx = nttc_pkg::bitrev(idx6, logn_q);
	assign cur_len = {1'b0, (bank_q ? l2_q : l1_q)};
	assign out_free = !out_valid_q || result_chan.ready;
	assign out_load = out_free && ((st_q == S_EOUT) || (st_q == S_ZEMIT && idx_q != total_q));
	assign pl1 = nttc_pkg::eff_len(cfg.len1);
	assign pl2 = nttc_pkg::eff_len(cfg.len2);
	assign ptotal = {1'b0, pl1} + {1'b0, pl2} - 1'b1;

	assign q_pop = (st_q == S_IDLE) && !q_empty;
	assign store_we = q_pop && q_head.wr;
	assign mm_req = mm_req_q;
	assign result_chan.valid = out_valid_q;
	assign result_chan.product_coeff = out_data_q;
	assign result_chan.last_coeff = out_last_q;

	always_comb begin
		work_we = 1'b0;
		work_wa = '0;
		work_wd = '0;
		work_ra = '0;
		case (st_q)
			S_LRD: begin
				if (idx_q != n7 && idx_q >= cur_len) begin
					work_we = 1'b1;
					work_wa = {bank_q, rev_idx};
				end
			end
			S_LWR: begin
				work_we = 1'b1;
				work_wa = {bank_q, rev_idx};
				work_wd = mres_q;
			end
			S_TBF: work_ra = {bank_q, bot};
			S_TRU: work_ra = {bank_q, top};
			S_TU: begin
				work_we = 1'b1;
				work_wa = {bank_q, top};
				work_wd = nttc_pkg::add_mod(work_rd_q, v_q, p);
			end
			S_TWB: begin
				work_we = 1'b1;
				work_wa = {bank_q, bot};
				work_wd = nttc_pkg::sub_mod(u_q, v_q, p);
			end
			S_PRA: work_ra = {1'b0, idx6};
			S_PRB: work_ra = {1'b1, idx6};
			S_PWR: begin
				work_we = 1'b1;
				work_wa = {1'b0, idx6};
				work_wd = mres_q;
			end
			S_CRD: work_ra = {1'b0, idx6};
			S_CWR: begin
				work_we = 1'b1;
				work_wa = {1'b1, rev_idx};
				work_wd = work_rd_q;
			end
			S_ERD: work_ra = {1'b1, idx6};
			default: work_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (work_we)
			work_mem[work_wa] <= work_wd;
		work_rd_q <= work_mem[work_ra];
		if (store_we)
			store_mem[{q_head.kind, q_head.idx}] <= q_head.coeff;
		store_rd_q <= store_mem[{bank_q, idx_q[IW-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			mret_q <= S_IDLE;
			pret_q <= S_IDLE;
			tphase_q <= TP_FA;
			bank_q <= 1'b0;
			l1_q <= '0;
			l2_q <= '0;
			total_q <= '0;
			logn_q <= '0;
			stage_q <= '0;
			idx_q <= '0;
			k_q <= '0;
			g_q <= '0;
			ginv_q <= '0;
			ninv_q <= '0;
			troot_q <= '0;
			wl_q <= '0;
			w_q <= '0;
			u_q <= '0;
			v_q <= '0;
			mres_q <= '0;
			pw_r_q <= '0;
			pw_b_q <= '0;
			pw_e_q <= '0;
			mm_req_q <= '0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (result_chan.ready && !out_load)
				out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (!q_empty && q_head.trig)
						st_q <= S_PREP;
				end
				S_PREP: begin
					l1_q <= pl1;
					l2_q <= pl2;
					total_q <= ptotal;
					logn_q <= nttc_pkg::ceil_log2(ptotal);
					idx_q <= '0;
					if (p < CW'(2)) begin
						st_q <= S_ZEMIT;
					end else begin
						mm_req_q <= '{start: 1'b1, a: CW'(1), b: cfg.root};
						mret_q <= S_GSET;
						st_q <= S_MWAIT;
					end
				end
				S_GSET: begin
					g_q <= mres_q;
					pw_r_q <= CW'(1);
					pw_b_q <= mres_q;
					pw_e_q <= p - CW'(2);
					pret_q <= S_GINVSET;
					st_q <= S_PLOOP;
				end
				S_GINVSET: begin
					ginv_q <= pw_r_q;
					mm_req_q <= '{start: 1'b1, a: CW'(1), b: CW'(n7)};
					mret_q <= S_NSET;
					st_q <= S_MWAIT;
				end
				S_NSET: begin
					pw_r_q <= CW'(1);
					pw_b_q <= mres_q;
					pw_e_q <= p - CW'(2);
					pret_q <= S_NINVSET;
					st_q <= S_PLOOP;
				end
				S_NINVSET: begin
					ninv_q <= pw_r_q;
					idx_q <= '0;
					bank_q <= 1'b0;
					st_q <= S_LRD;
				end
				S_LRD: begin
					if (idx_q == n7) begin
						idx_q <= '0;
						if (!bank_q) begin
							bank_q <= 1'b1;
						end else begin
							bank_q <= 1'b0;
							troot_q <= g_q;
							stage_q <= nttc_pkg::LOGN_W'(1);
							tphase_q <= TP_FA;
							st_q <= S_TSTG;
						end
					end else if (idx_q < cur_len) begin
						st_q <= S_LMOD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_LMOD: begin
					mm_req_q <= '{start: 1'b1, a: CW'(1), b: store_rd_q};
					mret_q <= S_LWR;
					st_q <= S_MWAIT;
				end
				S_LWR: begin
					idx_q <= idx_q + 1'b1;
					st_q <= S_LRD;
				end
				S_TSTG: begin
					if (stage_q > logn_q) begin
						idx_q <= '0;
						case (tphase_q)
							TP_FA: begin
								bank_q <= 1'b1;
								stage_q <= nttc_pkg::LOGN_W'(1);
								tphase_q <= TP_FB;
							end
							TP_FB: st_q <= S_PRA;
							default: st_q <= S_ERD;
						endcase
					end else begin
						pw_r_q <= CW'(1);
						pw_b_q <= troot_q;
						pw_e_q <= (p - CW'(1)) >> stage_q;
						pret_q <= S_TWL;
						st_q <= S_PLOOP;
					end
				end
				S_TWL: begin
					wl_q <= pw_r_q;
					k_q <= '0;
					st_q <= S_TBF;
				end
				S_TBF: begin
					if ({1'b0, k_q} == (n7 >> 1)) begin
						stage_q <= stage_q + 1'b1;
						st_q <= S_TSTG;
					end else begin
						if ((k_q & hm) == '0)
							w_q <= CW'(1);
						st_q <= S_TMV;
					end
				end
				S_TMV: begin
					mm_req_q <= '{start: 1'b1, a: work_rd_q, b: w_q};
					mret_q <= S_TRU;
					st_q <= S_MWAIT;
				end
				S_TRU: begin
					v_q <= mres_q;
					st_q <= S_TU;
				end
				S_TU: begin
					u_q <= work_rd_q;
					st_q <= S_TWB;
				end
				S_TWB: begin
					mm_req_q <= '{start: 1'b1, a: w_q, b: wl_q};
					mret_q <= S_TW;
					st_q <= S_MWAIT;
				end
				S_TW: begin
					w_q <= mres_q;
					k_q <= k_q + 1'b1;
					st_q <= S_TBF;
				end
				S_PRA: begin
					if (idx_q == n7) begin
						idx_q <= '0;
						st_q <= S_CRD;
					end else begin
						st_q <= S_PRB;
					end
				end
				S_PRB: begin
					u_q <= work_rd_q;
					st_q <= S_PMUL;
				end
				S_PMUL: begin
					mm_req_q <= '{start: 1'b1, a: u_q, b: work_rd_q};
					mret_q <= S_PWR;
					st_q <= S_MWAIT;
				end
				S_PWR: begin
					idx_q <= idx_q + 1'b1;
					st_q <= S_PRA;
				end
				S_CRD: begin
					if (idx_q == n7) begin
						bank_q <= 1'b1;
						troot_q <= ginv_q;
						stage_q <= nttc_pkg::LOGN_W'(1);
						tphase_q <= TP_INV;
						st_q <= S_TSTG;
					end else begin
						st_q <= S_CWR;
					end
				end
				S_CWR: begin
					idx_q <= idx_q + 1'b1;
					st_q <= S_CRD;
				end
				S_ERD: begin
					if (idx_q == total_q)
						st_q <= S_IDLE;
					else
						st_q <= S_EMUL;
				end
				S_EMUL: begin
					mm_req_q <= '{start: 1'b1, a: work_rd_q, b: ninv_q};
					mret_q <= S_EOUT;
					st_q <= S_MWAIT;
				end
				S_EOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q <= mres_q;
						out_last_q <= (idx_q + 1'b1 == total_q);
						idx_q <= idx_q + 1'b1;
						st_q <= S_ERD;
					end
				end
				S_ZEMIT: begin
					if (idx_q == total_q) begin
						st_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q <= '0;
						out_last_q <= (idx_q + 1'b1 == total_q);
						idx_q <= idx_q + 1'b1;
					end
				end
				S_PLOOP: begin
					if (pw_e_q == '0) begin
						st_q <= pret_q;
					end else if (pw_e_q[0]) begin
						mm_req_q <= '{start: 1'b1, a: pw_r_q, b: pw_b_q};
						mret_q <= S_PR;
						st_q <= S_MWAIT;
					end else begin
						mm_req_q <= '{start: 1'b1, a: pw_b_q, b: pw_b_q};
						mret_q <= S_PB;
						st_q <= S_MWAIT;
					end
				end
				S_PR: begin
					pw_r_q <= mres_q;
					mm_req_q <= '{start: 1'b1, a: pw_b_q, b: pw_b_q};
					mret_q <= S_PB;
					st_q <= S_MWAIT;
				end
				S_PB: begin
					pw_b_q <= mres_q;
					pw_e_q <= pw_e_q >> 1;
					st_q <= S_PLOOP;
				end
				S_MWAIT: begin
					mm_req_q.start <= 1'b0;
					if (mm_rsp.done) begin
						mres_q <= mm_rsp.res;
						st_q <= mret_q;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/ntt_convolution.sv
// top level: config registers, front, queue, sequencer and modular multiplier
// loading: one coefficient item a cycle while the queue has room, up to four items queued while the sequencer is busy
// a run starts once both sequences are full and goes through one bit-serial multiplier
// (one product at a time): 2 + 3*log2 n exponentiations of up to 124 products, plus
// 3*n*log2 n + n + len1 + len2 + results + 2 products; one result per product
// arst_n clears counts, queue, sequencer and output; config returns to reset values
`include "assert_macros.svh"
module ntt_convolution (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [nttc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [nttc_pkg::CW-1:0] cfg_wdata,
	nttc_in_if.sink coeff_chan,
	nttc_out_if.source result_chan
);
	nttc_pkg::cfg_t cfg_q;
	nttc_pkg::qent_t q_ent;
	nttc_pkg::qent_t q_head;
	nttc_pkg::mm_req_t mm_req;
	nttc_pkg::mm_rsp_t mm_rsp;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prime <= nttc_pkg::PRIME_RST;
			cfg_q.root <= nttc_pkg::ROOT_RST;
			cfg_q.len1 <= nttc_pkg::LEN_RST;
			cfg_q.len2 <= nttc_pkg::LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				nttc_pkg::REG_PRIME: cfg_q.prime <= cfg_wdata;
				nttc_pkg::REG_ROOT: cfg_q.root <= cfg_wdata;
				nttc_pkg::REG_LEN1: cfg_q.len1 <= cfg_wdata[nttc_pkg::LEN_W-1:0];
				nttc_pkg::REG_LEN2: cfg_q.len2 <= cfg_wdata[nttc_pkg::LEN_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	nttc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.coeff_chan(coeff_chan),
		.q_full(q_full),
		.q_push(q_push),
		.q_ent(q_ent)
	);

	nttc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_ent(q_ent),
		.full(q_full),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty)
	);

	nttc_modmul u_modmul (
		.clk(clk),
		.arst_n(arst_n),
		.prime(cfg_q.prime),
		.req(mm_req),
		.rsp(mm_rsp)
	);

	nttc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.mm_req(mm_req),
		.mm_rsp(mm_rsp),
		.result_chan(result_chan)
	);

	`ASSERT_IMPLIES(a_push_not_full, q_push, !q_full, "queue push while full")
	`ASSERT_IMPLIES(a_pop_not_empty, q_pop, !q_empty, "queue pop while empty")
	`ASSERT_IMPLIES(a_mul_idle_start, mm_req.start, !mm_rsp.busy, "multiply started while busy")
	`ASSERT_HOLDS(a_done_not_busy, !(mm_rsp.done && mm_rsp.busy), "multiplier done while busy")
endmodule

FILE: tb/tb_ntt_convolution.sv
// testbench of ntt_convolution: directed and random loads checked against a behavioral predictor
module tb_ntt_convolution;
	import nttc_pkg::*;

	typedef logic [63:0] word_t;
	typedef word_t vec_t [PTS];
	typedef struct {
		logic [CW-1:0] coeff;
		logic last;
	} conv_out_t;

	localparam word_t MASK62 = 64'h3FFF_FFFF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CW-1:0] cfg_wdata;

	nttc_in_if coeff_chan();
	nttc_out_if result_chan();

	ntt_convolution u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.coeff_chan(coeff_chan),
		.result_chan(result_chan)
	);

	// predictor state
	word_t mdl_prime;
	word_t mdl_root;
	logic [LEN_W-1:0] mdl_len1;
	logic [LEN_W-1:0] mdl_len2;
	word_t seq_a [PTS];
	word_t seq_b [PTS];
	int cnt_a;
	int cnt_b;
	conv_out_t conv_expected [$];

	int errors;
	int items_sent;
	int convs_done;
	int results_seen;
	bit idle_on;
	int hold_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#1000000000;
		$display("timeout");
		$display("Verification failed");
		$finish;
	end

	function automatic word_t mulm(word_t a, word_t b, word_t p);
		logic [127:0] t;
		t = a * b;
		return word_t'(t % p);
	endfunction

	function automatic word_t addm(word_t a, word_t b, word_t p);
		word_t s;
		s = a + b;
		return (s >= p) ? s - p : s;
	endfunction

	function automatic word_t subm(word_t a, word_t b, word_t p);
		return (a >= b) ? a - b : a + p - b;
	endfunction

	function automatic word_t powm(word_t base, word_t e, word_t p);
		word_t r;
		r = 64'd1 % p;
		base = base % p;
		while (e != 0) begin
			if (e[0])
				r = mulm(r, base, p);
			base = mulm(base, base, p);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic vec_t ntt(vec_t x, int n, int logn, word_t root, word_t p);
		int r;
		int len;
		int half;
		word_t t;
		word_t wl;
		word_t w;
		word_t u;
		word_t v;
		for (int i = 0; i < n; i++) begin
			r = 0;
			for (int k = 0; k < logn; k++)
				r |= ((i >> k) & 1) << (logn - 1 - k);
			if (i < r) begin
				t = x[i];
				x[i] = x[r];
				x[r] = t;
			end
		end
		for (len = 2; len <= n; len = len * 2) begin
			wl = powm(root, (p - 1) / len, p);
			half = len / 2;
			for (int i = 0; i < n; i += len) begin
				w = 1;
				for (int j = 0; j < half; j++) begin
					u = x[i + j];
					v = mulm(x[i + j + half], w, p);
					x[i + j] = addm(u, v, p);
					x[i + j + half] = subm(u, v, p);
					w = mulm(w, wl, p);
				end
			end
		end
		return x;
	endfunction

	function automatic int clip_len(logic [LEN_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_LEN)
			return MAX_LEN;
		return int'(v);
	endfunction

	// loads one coefficient and, once both sequences are full, queues the convolution
	task automatic predict_convolution(logic kind, logic [CW-1:0] value);
		int l1;
		int l2;
		int total;
		int n;
		int logn;
		word_t p;
		word_t g;
		word_t ginv;
		word_t ninv;
		vec_t xa;
		vec_t xb;
		conv_out_t e;
		l1 = clip_len(mdl_len1);
		l2 = clip_len(mdl_len2);
		p = mdl_prime;
		if (!kind) begin
			if (cnt_a < l1)
				seq_a[cnt_a++] = word_t'(value);
		end else if (cnt_b < l2) begin
			seq_b[cnt_b++] = word_t'(value);
		end
		if (cnt_a < l1 || cnt_b < l2)
			return;
		total = l1 + l2 - 1;
		n = 1;
		logn = 0;
		while (n < total && n < PTS) begin
			n *= 2;
			logn++;
		end
		if (total > n)
			total = n;
		if (p < 2) begin
			for (int i = 0; i < total; i++)
				xa[i] = '0;
		end else begin
			g = mdl_root % p;
			ginv = powm(g, p - 2, p);
			ninv = powm(word_t'(n) % p, p - 2, p);
			for (int i = 0; i < PTS; i++) begin
				xa[i] = (i < l1 && i < n) ? seq_a[i] % p : '0;
				xb[i] = (i < l2 && i < n) ? seq_b[i] % p : '0;
			end
			xa = ntt(xa, n, logn, g, p);
			xb = ntt(xb, n, logn, g, p);
			for (int i = 0; i < n; i++)
				xa[i] = mulm(xa[i], xb[i], p);
			xa = ntt(xa, n, logn, ginv, p);
			for (int i = 0; i < total; i++)
				xa[i] = mulm(xa[i], ninv, p);
		end
		for (int i = 0; i < total; i++) begin
			e.coeff = xa[i][CW-1:0];
			e.last = (i + 1 == total);
			conv_expected = {conv_expected, e};
		end
		cnt_a = 0;
		cnt_b = 0;
		convs_done++;
	endtask

	task automatic send_coeff(logic kind, logic [CW-1:0] value);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			coeff_chan.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		coeff_chan.valid = 1'b1;
		coeff_chan.kind = kind;
		coeff_chan.coeff_value = value;
		do
			@(posedge clk);
		while (!coeff_chan.ready);
		predict_convolution(kind, value);
		items_sent++;
		@(negedge clk);
		coeff_chan.valid = 1'b0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value[CW-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_PRIME: mdl_prime = value & MASK62;
			REG_ROOT: mdl_root = value & MASK62;
			REG_LEN1: mdl_len1 = value[LEN_W-1:0];
			REG_LEN2: mdl_len2 = value[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_field(word_t p, word_t g, int l1, int l2);
		write_reg(REG_PRIME, p);
		write_reg(REG_ROOT, g);
		write_reg(REG_LEN1, word_t'(l1));
		write_reg(REG_LEN2, word_t'(l2));
	endtask

	task automatic drain;
		while (conv_expected.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coeff();
		return CW'({$urandom, $urandom});
	endfunction

	// result checker
	always @(posedge clk) begin
		conv_out_t e;
		if (arst_n && result_chan.valid && result_chan.ready) begin
			results_seen++;
			if (conv_expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item %h last %b", result_chan.product_coeff,
						result_chan.last_coeff);
			end else begin
				e = conv_expected.pop_front();
				if (e.coeff !== result_chan.product_coeff || e.last !== result_chan.last_coeff) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h last %b, got %h last %b", e.coeff,
							e.last, result_chan.product_coeff, result_chan.last_coeff);
				end
			end
		end
	end

	// receiver stalls: random bursts plus a long hold-off
	initial begin
		int burst;
		burst = 0;
		result_chan.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_chan.ready = 1'b0;
			end else if (burst > 0) begin
				burst--;
				result_chan.ready = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(0, 3);
				result_chan.ready = 1'b0;
			end else begin
				result_chan.ready = 1'b1;
			end
		end
	end

	task automatic test_reset_values;
		send_coeff(1'b0, 62'd5);
		send_coeff(1'b1, 62'd7);
		send_coeff(1'b1, '1);
		send_coeff(1'b0, '0);
		drain();
	endtask

	task automatic test_modulus_extremes;
		set_field(64'd0, 64'd3, 2, 1);
		send_coeff(1'b0, 62'd9);
		send_coeff(1'b0, 62'd4);
		send_coeff(1'b1, 62'd2);
		drain();
		write_reg(REG_PRIME, 64'd1);
		send_coeff(1'b1, 62'd2);
		send_coeff(1'b0, 62'd1);
		send_coeff(1'b0, '1);
		drain();
		set_field(MASK62, MASK62, 1, 1);
		send_coeff(1'b0, '1);
		send_coeff(1'b1, 62'h2AAA_AAAA_AAAA_AAAA);
		drain();
		set_field(64'd3, 64'd2, 1, 2);
		send_coeff(1'b1, '1);
		send_coeff(1'b1, 62'd2);
		send_coeff(1'b0, 62'd1);
		drain();
	endtask

	task automatic test_length_cases;
		// zero acts as one; extra items go nowhere
		set_field(64'd17, 64'd3, 0, 2);
		send_coeff(1'b0, 62'd3);
		send_coeff(1'b0, 62'd11);
		send_coeff(1'b1, 62'd4);
		send_coeff(1'b1, 62'd16);
		drain();
		// shorten the first sequence after three were loaded
		set_field(64'd97, 64'd5, 4, 1);
		send_coeff(1'b0, 62'd10);
		send_coeff(1'b0, 62'd20);
		send_coeff(1'b0, 62'd30);
		repeat (40) @(negedge clk);
		write_reg(REG_LEN1, 64'd2);
		send_coeff(1'b1, 62'd96);
		drain();
		// longest sequences, the first given oversized
		set_field(64'd17, 64'd3, 63, 32);
		for (int i = 0; i < 32; i++) begin
			send_coeff(1'b0, rand_coeff());
			send_coeff(1'b1, rand_coeff());
		end
		drain();
	endtask

	task automatic test_backpressure;
		set_field(64'd97, 64'd5, 2, 2);
		hold_cycles = 40000;
		for (int i = 0; i < 12; i++)
			send_coeff(i[0], rand_coeff());
		drain();
	endtask

	task automatic test_random_convolutions;
		word_t primes [6] = '{64'd17, 64'd97, 64'd257, 64'd7681, 64'd3, 64'd998244353};
		word_t roots [6] = '{64'd3, 64'd5, 64'd3, 64'd17, 64'd2, 64'd3};
		int sel;
		int start;
		start = items_sent;
		while (items_sent - start < 80) begin
			if (items_sent - start > 50)
				idle_on = 1'b0;
			sel = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 3);
			set_field(primes[sel], roots[sel], $urandom_range(1, 3), $urandom_range(1, 3));
			do
				send_coeff(1'($urandom_range(0, 1)),
					($urandom_range(0, 3) == 0) ? rand_coeff() :
					CW'($urandom_range(0, int'(primes[sel] > 64'hFFFF ? 64'hFFFF : primes[sel]))));
			while (cnt_a != 0 || cnt_b != 0);
			drain();
		end
	endtask

	initial begin
		errors = 0;
		items_sent = 0;
		convs_done = 0;
		results_seen = 0;
		hold_cycles = 0;
		idle_on = 1'b1;
		cnt_a = 0;
		cnt_b = 0;
		mdl_prime = 64'd998244353;
		mdl_root = 64'd3;
		mdl_len1 = LEN_RST;
		mdl_len2 = LEN_RST;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		coeff_chan.valid = 1'b0;
		coeff_chan.kind = 1'b0;
		coeff_chan.coeff_value = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_reset_values();
		test_modulus_extremes();
		test_length_cases();
		test_backpressure();
		test_random_convolutions();

		repeat (100) @(negedge clk);
		if (conv_expected.size() != 0)
			errors++;
		$display("%0d coefficient items sent, %0d convolutions, %0d result items checked",
			items_sent, convs_done, results_seen);
		$display("covered modulus and length extremes, ignored items and a long output stall");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d errors", errors);
			$display("Verification failed");
		end
		$finish;
	end
endmodule

FILE: ntt_convolution.f
+incdir+rtl
rtl/nttc_pkg.sv
rtl/nttc_if.sv
rtl/nttc_queue.sv
rtl/nttc_front.sv
rtl/nttc_modmul.sv
rtl/nttc_back.sv
rtl/ntt_convolution.sv
tb/tb_ntt_convolution.sv
